// ===== rtl/core/gti_pkg.sv =====
// ----------------------------------------------------------------------------
// gti_pkg: shared types and constants of the grid trilinear interpolator
// Beat payloads, configuration set, front-to-back job and lane phases.
// ----------------------------------------------------------------------------
package gti_pkg;

	localparam int IDX_W  = 11;
	localparam int FRAC_W = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

	// input kinds
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_NX        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_NY        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_NZ        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_XY        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_ETA       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_STEP_XY  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_STEP_ETA = 3'd6;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_eta;
		logic [31:0]        load_value;
	} item_t;

	typedef struct packed {
		logic [31:0] interp_value;
		logic        inside_res;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] grid_nx;
		logic [IDX_W-1:0] grid_ny;
		logic [IDX_W-1:0] grid_nz;
		logic [31:0]      step_xy;
		logic [31:0]      step_eta;
		logic [31:0]      recip_step_xy;
		logic [31:0]      recip_step_eta;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_APPEND,
		OP_QUERY,
		OP_CLEAR
	} op_t;

	// work handed from front to back through the queue
	typedef struct packed {
		op_t               op;
		logic [31:0]       value;
		logic [IDX_W-1:0]  ix;
		logic [IDX_W-1:0]  iy;
		logic [IDX_W-1:0]  ie;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [FRAC_W-1:0] fe;
		logic              outside;
	} job_t;

	// step of the per-axis locate lanes
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LOAD,
		PH_MUL,
		PH_SETUP,
		PH_DIV,
		PH_FRAC
	} phase_t;

endpackage

// ===== rtl/core/gti_axis.sv =====
// ----------------------------------------------------------------------------
// gti_axis: one-axis cell locator
// Centers the coordinate, divides by the spacing one quotient bit a cycle,
// and scales the remainder by the reciprocal spacing into a Q1.16 fraction.
// ----------------------------------------------------------------------------
module gti_axis import gti_pkg::*; (
	input  logic              clk,
	input  phase_t            phase,
	input  logic signed [31:0] pos,
	input  logic [IDX_W-1:0]  n,
	input  logic [31:0]       step,
	input  logic [31:0]       recip,
	output logic [IDX_W-1:0]  idx,
	output logic [FRAC_W-1:0] frac,
	output logic              outside
);

	logic signed [31:0] pos_q;
	logic [41:0]        off_q;
	logic [31:0]        rem_q;
	logic [IDX_W-1:0]   au_lo_q;
	logic [IDX_W-1:0]   quo_q;
	logic               div_q;
	logic               out_q;
	logic [FRAC_W-1:0]  frac_q;

	logic [43:0] u;
	logic [43:0] au;
	logic        neg;
	logic [32:0] t;
	logic        ge;
	logic [63:0] prod;

	// centered coordinate and its magnitude
	assign u   = {{12{pos_q[31]}}, pos_q} + {2'b00, off_q};
	assign neg = u[43];
	assign au  = neg ? (44'd0 - u) : u;

	// restoring division step
	assign t    = {rem_q, au_lo_q[IDX_W-1]};
	assign ge   = (t >= {1'b0, step});
	assign prod = 64'(rem_q) * 64'(recip);

	always_ff @(posedge clk) begin
		case (phase)
			PH_LOAD: begin
				pos_q <= pos;
			end
			PH_MUL: begin
				off_q <= 42'(n[IDX_W-1:1]) * 42'(step);
			end
			PH_SETUP: begin
				// negative side only reaches cell 0; positive side needs < 2^11 cells
				quo_q   <= '0;
				div_q   <= !neg;
				au_lo_q <= au[IDX_W-1:0];
				if (neg) begin
					out_q <= (au >= {12'd0, step});
					rem_q <= au[31:0];
				end else begin
					out_q <= (au >= {1'b0, step, 11'd0});
					rem_q <= au[42:11];
				end
			end
			PH_DIV: begin
				if (div_q) begin
					rem_q   <= ge ? 32'(t - {1'b0, step}) : t[31:0];
					quo_q   <= {quo_q[IDX_W-2:0], ge};
					au_lo_q <= {au_lo_q[IDX_W-2:0], 1'b0};
				end
			end
			PH_FRAC: begin
				frac_q <= (prod[63:16] > 48'(ONE_Q16)) ? ONE_Q16 : prod[32:16];
				out_q  <= out_q | (quo_q >= n);
			end
			default: begin
			end
		endcase
	end

	assign idx     = quo_q;
	assign frac    = frac_q;
	assign outside = out_q;

endmodule

// ===== rtl/core/gti_front.sv =====
// ----------------------------------------------------------------------------
// gti_front: command intake and point locator
// Accepts beats, runs three axis lanes for a query, and pushes one job per
// table operation into the queue toward the back end.
// ----------------------------------------------------------------------------
module gti_front import gti_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	input  cfg_t  cfg,
	input  logic  full,
	output logic  busy,
	output logic  push,
	output job_t  job
);

	typedef enum logic [5:0] {
		F_IDLE  = 6'b000001,
		F_MUL   = 6'b000010,
		F_SETUP = 6'b000100,
		F_DIV   = 6'b001000,
		F_FRAC  = 6'b010000,
		F_PUSH  = 6'b100000
	} fstate_t;

	fstate_t     state_q;
	logic [3:0]  cnt_q;
	op_t         op_q;
	logic [31:0] value_q;
	logic        accept;
	phase_t      phase;

	logic [IDX_W-1:0]  ix, iy, ie;
	logic [FRAC_W-1:0] fx, fy, fe;
	logic              ox, oy, oe;

	assign busy   = (state_q != F_IDLE);
	assign accept = start && !busy;
	assign push   = (state_q == F_PUSH) && !full;

	// lane step
	always_comb begin
		case (state_q)
			F_IDLE:  phase = (accept && item.kind == KIND_QUERY) ? PH_LOAD : PH_IDLE;
			F_MUL:   phase = PH_MUL;
			F_SETUP: phase = PH_SETUP;
			F_DIV:   phase = PH_DIV;
			F_FRAC:  phase = PH_FRAC;
			default: phase = PH_IDLE;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						case (item.kind)
							KIND_QUERY:  state_q <= F_MUL;
							KIND_APPEND: state_q <= F_PUSH;
							KIND_CLEAR:  state_q <= F_PUSH;
							default:     state_q <= F_IDLE;
						endcase
					end
				end
				F_MUL:   state_q <= F_SETUP;
				F_SETUP: begin
					state_q <= F_DIV;
					cnt_q   <= '0;
				end
				F_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(IDX_W - 1))
						state_q <= F_FRAC;
				end
				F_FRAC:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// job kind and append value
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= item.load_value;
			case (item.kind)
				KIND_APPEND: op_q <= OP_APPEND;
				KIND_CLEAR:  op_q <= OP_CLEAR;
				default:     op_q <= OP_QUERY;
			endcase
		end
	end

	gti_axis u_axis_x (
		.clk(clk), .phase(phase), .pos(item.pos_x), .n(cfg.grid_nx),
		.step(cfg.step_xy), .recip(cfg.recip_step_xy),
		.idx(ix), .frac(fx), .outside(ox)
	);

	gti_axis u_axis_y (
		.clk(clk), .phase(phase), .pos(item.pos_y), .n(cfg.grid_ny),
		.step(cfg.step_xy), .recip(cfg.recip_step_xy),
		.idx(iy), .frac(fy), .outside(oy)
	);

	gti_axis u_axis_e (
		.clk(clk), .phase(phase), .pos(item.pos_eta), .n(cfg.grid_nz),
		.step(cfg.step_eta), .recip(cfg.recip_step_eta),
		.idx(ie), .frac(fe), .outside(oe)
	);

	always_comb begin
		job.op      = op_q;
		job.value   = value_q;
		job.ix      = ix;
		job.iy      = iy;
		job.ie      = ie;
		job.fx      = fx;
		job.fy      = fy;
		job.fe      = fe;
		job.outside = ox | oy | oe;
	end

endmodule

// ===== rtl/core/gti_back.sv =====
// ----------------------------------------------------------------------------
// gti_back: grid table and corner accumulator
// Owns the value table and its fill count; walks the eight corners of a
// query through a read, weight-multiply and accumulate pipeline.
// ----------------------------------------------------------------------------
module gti_back import gti_pkg::*; #(
	parameter int TABLE_DEPTH = 65536,
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  job_t             job,
	input  logic             avail,
	input  logic [IDX_W-1:0] grid_nx,
	input  logic [IDX_W-1:0] grid_ny,
	output logic             pop,
	output logic             done,
	output result_t          result
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int DW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int ACC_W = DW + FRAC_W + 3;
	localparam int LI_W  = 35;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_W    = 5'b00010,
		B_E    = 5'b00100,
		B_F    = 5'b01000,
		B_RUN  = 5'b10000
	} bstate_t;

	logic [DW-1:0] mem [TABLE_DEPTH];

	bstate_t           state_q;
	logic [CW-1:0]     count_q;
	logic [3:0]        cnt_q;
	job_t              job_q;
	logic [FRAC_W-1:0] wxy_q [4];
	logic [21:0]       nxny_q;
	logic [21:0]       xb0_q;
	logic [22:0]       xb1_q;
	logic [32:0]       eb0_q;
	logic [33:0]       eb1_q;
	logic              bad_q;
	logic [ACC_W-1:0]  acc_q;
	logic              done_q;
	result_t           res_q;

	logic              v_s1, v_s2;
	logic [FRAC_W-1:0] w_s1;
	logic [DW-1:0]     rd_s1;
	logic [FRAC_W+DW-1:0] prod_s2;

	logic [FRAC_W-1:0] wx0, wy0, we0;
	logic [2:0]        k;
	logic [LI_W-1:0]   li;
	logic              issue;
	logic              wr_en;
	logic [33:0]       wprod;
	logic [DW+3:0]     sh;
	logic [DW-1:0]     sat;

	assign pop   = (state_q == B_IDLE) && avail;
	assign wr_en = pop && (job.op == OP_APPEND) && (count_q < CW'(TABLE_DEPTH));

	// complementary weights
	assign wx0 = ONE_Q16 - job_q.fx;
	assign wy0 = ONE_Q16 - job_q.fy;
	assign we0 = ONE_Q16 - job_q.fe;

	// corner k = {jx, jy, je}
	assign k     = cnt_q[2:0];
	assign issue = (state_q == B_RUN) && !cnt_q[3];
	assign li    = (k[0] ? LI_W'(eb1_q) : LI_W'(eb0_q))
	             + (k[2] ? LI_W'(xb1_q) : LI_W'(xb0_q))
	             + LI_W'(job_q.iy) + LI_W'(k[1]);
	assign wprod = 34'(wxy_q[k[2:1]]) * 34'(k[0] ? job_q.fe : we0);

	// saturated result
	assign sh  = acc_q[ACC_W-1:16];
	assign sat = (sh > (DW+4)'({DW{1'b1}})) ? {DW{1'b1}} : sh[DW-1:0];

	// table write and corner read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[AW-1:0]] <= DW'(job.value);
		if (issue)
			rd_s1 <= mem[li[AW-1:0]];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue;
			v_s2   <= v_s1;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						case (job.op)
							OP_APPEND: begin
								if (wr_en)
									count_q <= count_q + CW'(1);
							end
							OP_CLEAR: count_q <= '0;
							OP_QUERY: begin
								if (job.outside)
									done_q <= 1'b1;
								else
									state_q <= B_W;
							end
							default: begin
							end
						endcase
					end
				end
				B_W: state_q <= B_E;
				B_E: state_q <= B_F;
				B_F: begin
					state_q <= B_RUN;
					cnt_q   <= '0;
				end
				B_RUN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd10) begin
						done_q  <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pop)
			job_q <= job;
		if (pop && job.op == OP_QUERY && job.outside)
			res_q <= '0;
		case (state_q)
			B_W: begin
				nxny_q   <= 22'(grid_nx) * 22'(grid_ny);
				xb0_q    <= 22'(job_q.ix) * 22'(grid_ny);
				wxy_q[0] <= 17'((34'(wx0) * 34'(wy0)) >> 16);
				wxy_q[1] <= 17'((34'(wx0) * 34'(job_q.fy)) >> 16);
				wxy_q[2] <= 17'((34'(job_q.fx) * 34'(wy0)) >> 16);
				wxy_q[3] <= 17'((34'(job_q.fx) * 34'(job_q.fy)) >> 16);
				acc_q    <= '0;
				bad_q    <= 1'b0;
			end
			B_E: begin
				eb0_q <= 33'(job_q.ie) * 33'(nxny_q);
				xb1_q <= 23'(xb0_q) + 23'(grid_ny);
			end
			B_F: begin
				eb1_q <= 34'(eb0_q) + 34'(nxny_q);
			end
			B_RUN: begin
				if (issue && li >= LI_W'(count_q))
					bad_q <= 1'b1;
				if (v_s2)
					acc_q <= acc_q + ACC_W'(prod_s2);
				if (cnt_q == 4'd10) begin
					res_q.interp_value <= bad_q ? 32'd0 : 32'(sat);
					res_q.inside_res   <= !bad_q;
				end
			end
			default: begin
			end
		endcase
		w_s1    <= wprod[32:16];
		prod_s2 <= (FRAC_W+DW)'(w_s1) * (FRAC_W+DW)'(rd_s1);
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/core/grid_trilinear_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// grid_trilinear_interpolator_unit: Q16.16 trilinear lookup over a 3-D grid
// Top level: configuration registers, job queue, front locator, back table.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken when start is high and busy is low.
//   kind append adds load_value at the end of the table, clear empties it,
//   query returns one result beat; other kinds are dropped.
//   Result channel: done is high for one cycle with result valid; the
//   receiver must take it then.
//   A query holds busy from its accepting edge until its job is pushed (one
//   quotient bit a cycle over the 11-bit cell index, all three axes in
//   parallel) and then occupies the back for weight setup, eight corner
//   reads from the single-port table, one a cycle, and the multiply drain.
//   Append and clear hold busy until their job is pushed, which waits
//   while the job queue is full.
//   A two-entry job queue lets the front locate the next point while the
//   back still walks corners.
//   Configuration: write cfg_data to register cfg_idx with cfg_we, only
//   while the block is idle.
//   Reset restores register defaults and empties the table count; table
//   contents are not cleared.
// ----------------------------------------------------------------------------
module grid_trilinear_interpolator_unit import gti_pkg::*; #(
	parameter int TABLE_DEPTH = 65536,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  item_t                 item,
	output logic                  busy,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	job_t fifo_q [2];
	logic wr_q, rd_q;
	logic [1:0] fcnt_q;

	job_t front_job;
	logic push, pop, full, avail;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_nx        <= 11'd100;
			cfg_q.grid_ny        <= 11'd100;
			cfg_q.grid_nz        <= 11'd1;
			cfg_q.step_xy        <= 32'd13107;
			cfg_q.step_eta       <= 32'd30720;
			cfg_q.recip_step_xy  <= 32'd327680;
			cfg_q.recip_step_eta <= 32'd139810;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GRID_NX:        cfg_q.grid_nx        <= cfg_data[IDX_W-1:0];
				REG_GRID_NY:        cfg_q.grid_ny        <= cfg_data[IDX_W-1:0];
				REG_GRID_NZ:        cfg_q.grid_nz        <= cfg_data[IDX_W-1:0];
				REG_STEP_XY:        cfg_q.step_xy        <= cfg_data;
				REG_STEP_ETA:       cfg_q.step_eta       <= cfg_data;
				REG_RECIP_STEP_XY:  cfg_q.recip_step_xy  <= cfg_data;
				REG_RECIP_STEP_ETA: cfg_q.recip_step_eta <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gti_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .cfg(cfg_q),
		.full(full), .busy(busy), .push(push), .job(front_job)
	);

	// job queue between front and back
	assign full  = (fcnt_q == 2'd2);
	assign avail = (fcnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fcnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   fcnt_q <= fcnt_q + 2'd1;
				2'b01:   fcnt_q <= fcnt_q - 2'd1;
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= front_job;
	end

	gti_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .job(fifo_q[rd_q]), .avail(avail),
		.grid_nx(cfg_q.grid_nx), .grid_ny(cfg_q.grid_ny),
		.pop(pop), .done(done), .result(result)
	);

	// checks
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.inside_res |-> result.interp_value == 32'd0)
		else $error("outside result carries a nonzero value");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q != 2'd3)
		else $error("job queue count out of range");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == KIND_QUERY |=> busy)
		else $error("front idle right after taking a query");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full job queue");

endmodule

// ===== tb/gti_checker.sv =====
// ----------------------------------------------------------------------------
// gti_checker: scoreboard for the grid trilinear interpolator
// Tracks the register and table state from the channels it watches. It
// predicts each query result and compares result beats in order.
// ----------------------------------------------------------------------------
module gti_checker import gti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  item_t                 item,
	input  logic                  done,
	input  result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int DEPTH = 65536;

	cfg_t        regs;
	bit [31:0]   grid_mem [DEPTH];
	int unsigned fill_level;
	result_t     expected_q [$];

	assign pending = expected_q.size();

	// cell index and fraction along one axis; 0 when the point is outside
	function automatic bit axis_cell(input logic signed [31:0] pos, input bit [10:0] n,
			input bit [31:0] step, input bit [31:0] recip,
			output longint idx, output bit [63:0] frac);
		longint s, u, i, r;
		bit [63:0] ar;
		s = longint'({32'd0, step});
		u = longint'(pos) + longint'({53'd0, n >> 1}) * s;
		i = u / s;
		r = u - i * s;
		ar = (r < 0) ? -r : r;
		idx = i;
		frac = 0;
		if (i < 0 || i > longint'({53'd0, n}) - 1)
			return 0;
		frac = (ar * {32'd0, recip}) >> 16;
		if (frac > 64'h10000)
			frac = 64'h10000;
		return 1;
	endfunction

	function automatic result_t interp_point(input item_t it);
		result_t   res;
		longint    ix, iy, ie;
		bit [63:0] fx, fy, fe, wx, wy, we, w, acc, li;
		res = '0;
		acc = 0;
		if (regs.step_xy == 0 || regs.step_eta == 0)
			return res;
		if (!axis_cell(it.pos_x, regs.grid_nx, regs.step_xy, regs.recip_step_xy, ix, fx) ||
				!axis_cell(it.pos_y, regs.grid_ny, regs.step_xy, regs.recip_step_xy, iy, fy) ||
				!axis_cell(it.pos_eta, regs.grid_nz, regs.step_eta, regs.recip_step_eta, ie, fe))
			return res;
		for (int jx = 0; jx < 2; jx++)
			for (int jy = 0; jy < 2; jy++)
				for (int je = 0; je < 2; je++) begin
					li = (ie + je) * regs.grid_nx * regs.grid_ny + (ix + jx) * regs.grid_ny + iy + jy;
					if (li >= fill_level || li >= DEPTH)
						return res;
					wx = jx ? fx : 64'h10000 - fx;
					wy = jy ? fy : 64'h10000 - fy;
					we = je ? fe : 64'h10000 - fe;
					w = (((wx * wy) >> 16) * we) >> 16;
					acc += w * grid_mem[li];
				end
		acc >>= 16;
		res.interp_value = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
		res.inside_res = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_res;
		int      errs;
		if (!arst_n) begin
			regs <= '{grid_nx: 100, grid_ny: 100, grid_nz: 1, step_xy: 13107,
				step_eta: 30720, recip_step_xy: 327680, recip_step_eta: 139810};
			fill_level <= 0;
			expected_q.delete();
			fail_count <= 0;
		end else begin
			errs = 0;
			// register writes
			if (cfg_we) begin
				case (cfg_idx)
					REG_GRID_NX:        regs.grid_nx <= cfg_data[IDX_W-1:0];
					REG_GRID_NY:        regs.grid_ny <= cfg_data[IDX_W-1:0];
					REG_GRID_NZ:        regs.grid_nz <= cfg_data[IDX_W-1:0];
					REG_STEP_XY:        regs.step_xy <= cfg_data;
					REG_STEP_ETA:       regs.step_eta <= cfg_data;
					REG_RECIP_STEP_XY:  regs.recip_step_xy <= cfg_data;
					REG_RECIP_STEP_ETA: regs.recip_step_eta <= cfg_data;
					default: ;
				endcase
			end
			// command beat
			if (start && !busy) begin
				case (item.kind)
					KIND_APPEND: begin
						if (fill_level < DEPTH) begin
							grid_mem[fill_level] = item.load_value;
							fill_level <= fill_level + 1;
						end
					end
					KIND_CLEAR: fill_level <= 0;
					KIND_QUERY: expected_q.insert(expected_q.size(), interp_point(item));
					default: ;
				endcase
			end
			// result beat
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected: %h", result);
					errs++;
				end else begin
					exp_res = expected_q.pop_front();
					if (result.interp_value !== exp_res.interp_value) begin
						$error("interp_value: expected %h, got %h",
							exp_res.interp_value, result.interp_value);
						errs++;
					end
					if (result.inside_res !== exp_res.inside_res) begin
						$error("inside_res: expected %b, got %b",
							exp_res.inside_res, result.inside_res);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for grid_trilinear_interpolator_unit
// Loads grids of several shapes and spacings, then sends directed and random
// query points with random sender gaps; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_top import gti_pkg::*;;

	// kind and register index that the block ignores
	localparam logic [1:0]           KIND_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE  = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	item_t                 item;
	logic                  busy;
	logic                  done;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    gap_pct;

	grid_trilinear_interpolator_unit dut (.*);

	gti_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 4_000_000);
		$display("tb_top NOT OK");
		$finish;
	end

	// one command beat, with a random gap in front of it for gap_pct percent of beats
	task automatic send_beat(input item_t it);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_kind(input logic [1:0] k, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] e, input logic [31:0] v);
		item_t it;
		it.kind = k;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_eta = e;
		it.load_value = v;
		send_beat(it);
	endtask

	// hold off until the block has drained
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// one write cycle, then cfg_we low again before returning
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// point near the grid: mostly inside a cell, sometimes fully random
	function automatic logic [31:0] grid_coord(input int n, input logic [31:0] step);
		longint p;
		if ($urandom_range(99) < 15)
			return $urandom;
		p = longint'($urandom_range(n + 1)) * step - longint'(n / 2) * step
			+ ((step > 1) ? $urandom_range(step - 1) : 0) - $urandom_range(1);
		return p[31:0];
	endfunction

	int          nx_s [6] = '{4, 1, 5, 1024, 1, 0};
	int          ny_s [6] = '{3, 1, 2, 1, 1024, 3};
	int          nz_s [6] = '{2, 1, 3, 1, 1024, 2};
	logic [31:0] sxy_s [6] = '{32'h10000, 32'd1, 32'hFFFF_FFFF, 32'd3000, 32'h8000, 32'd0};
	logic [31:0] se_s [6] = '{32'h8000, 32'd1, 32'hFFFF_FFFF, 32'h10000, 32'h4000, 32'h10000};
	logic [31:0] rxy_s [6] = '{32'h10000, 32'hFFFF_FFFF, 32'd1, 32'd1431655, 32'h20000, 32'd5};
	logic [31:0] re_s [6] = '{32'h20000, 32'hFFFF_FFFF, 32'd1, 32'h10000, 32'h40000, 32'h10000};

	initial begin
		int fill;
		int kind_pick;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		gap_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table at reset defaults: every query falls outside
		send_kind(KIND_QUERY, 32'd0, 32'd0, 32'd0, 32'd0);
		send_kind(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(REG_GRID_NX, nx_s[ph]);
			write_reg(REG_GRID_NY, ny_s[ph]);
			write_reg(REG_GRID_NZ, nz_s[ph]);
			write_reg(REG_STEP_XY, sxy_s[ph]);
			write_reg(REG_STEP_ETA, se_s[ph]);
			write_reg(REG_RECIP_STEP_XY, rxy_s[ph]);
			write_reg(REG_RECIP_STEP_ETA, re_s[ph]);
			write_reg(REG_NONE, $urandom);
			gap_pct = 0;
			send_kind(KIND_CLEAR, 0, 0, 0, 0);
			// large grids get a partial table, so upper corners run past it
			fill = (nx_s[ph] * ny_s[ph] * (nz_s[ph] + 1) + ny_s[ph] + 2);
			if (fill > 48)
				fill = 48;
			for (int k = 0; k < fill; k++)
				send_kind(KIND_APPEND, $urandom, $urandom, $urandom,
					(k % 5 == 0) ? 32'hFFFF_FFFF : $urandom);

			if (ph == 0) begin
				// pins: extremes of the coordinates, grid corners, unused kind
				send_kind(KIND_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
				send_kind(KIND_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
				send_kind(KIND_QUERY, -32'sh20000, -32'sh10000, -32'sh8000, 0);
				send_kind(KIND_QUERY, -32'sh1, -32'sh1, -32'sh1, 0);
				send_kind(KIND_QUERY, 32'h10000, 32'h0, 32'h7FFF, 0);
				send_kind(KIND_QUERY, 32'h18000, 32'h4000, 32'h4000, 0);
				send_kind(KIND_QUERY, -32'sh20001, 32'h0, 32'h0, 0);
				send_kind(KIND_NONE, 32'h10000, 0, 0, 0);
				send_kind(KIND_APPEND, 0, 0, 0, 32'h0);
				send_kind(KIND_QUERY, 32'h10000, 32'h10000, 32'h0, 0);
				// sender holds off until the result is back
				drain();
				send_kind(KIND_QUERY, 32'h0, 32'h0, 32'h0, 0);
			end

			// random queries over the idling modes
			for (int q = 0; q < 64; q++) begin
				gap_pct = (q < 16) ? 0 : (q < 32) ? 71 : (q < 48) ? 0 : 28;
				kind_pick = $urandom_range(99);
				if (kind_pick < 3)
					send_kind(KIND_NONE, $urandom, $urandom, $urandom, $urandom);
				else if (kind_pick < 6)
					send_kind(KIND_APPEND, $urandom, $urandom, $urandom, $urandom);
				else
					send_kind(KIND_QUERY, grid_coord(nx_s[ph], sxy_s[ph]),
						grid_coord(ny_s[ph], sxy_s[ph]),
						grid_coord(nz_s[ph], se_s[ph]), $urandom);
			end
		end

		drain();
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
